@@ hdl/imae_pkg.sv @@
package imae_pkg;

   // field and datapath widths
   localparam int COMP_W    = 32;
   localparam int WEIGHT_W  = 31;
   localparam int AREA_W    = 31;
   localparam int MUL_W     = 33;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int RAD_W     = 64;
   localparam int ROOT_W    = 32;
   localparam int NUM_COMP  = 6;
   localparam int NUM_TERMS = 21;
   localparam int TERM_W    = 5;

   // request modes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_CALC = 1'b1;

   // metric store entries
   localparam logic [2:0] G_XX = 3'd0;
   localparam logic [2:0] G_XY = 3'd1;
   localparam logic [2:0] G_XZ = 3'd2;
   localparam logic [2:0] G_YY = 3'd3;
   localparam logic [2:0] G_YZ = 3'd4;
   localparam logic [2:0] G_ZZ = 3'd5;

   // tangent component selects
   localparam logic [2:0] SEL_TX = 3'd0;
   localparam logic [2:0] SEL_TY = 3'd1;
   localparam logic [2:0] SEL_TZ = 3'd2;
   localparam logic [2:0] SEL_FX = 3'd3;
   localparam logic [2:0] SEL_FY = 3'd4;
   localparam logic [2:0] SEL_FZ = 3'd5;

   typedef struct packed {
      logic                     mode;
      logic signed [COMP_W-1:0] comp_a;
      logic signed [COMP_W-1:0] comp_b;
      logic signed [COMP_W-1:0] comp_c;
      logic signed [COMP_W-1:0] comp_d;
      logic signed [COMP_W-1:0] comp_e;
      logic signed [COMP_W-1:0] comp_f;
      logic [WEIGHT_W-1:0]      quad_weight;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] gamma_tt;
      logic signed [COMP_W-1:0] gamma_tp;
      logic signed [COMP_W-1:0] gamma_pp;
      logic [AREA_W-1:0]        area_element;
   } rsp_type;

   typedef enum logic [1:0] {
      DST_TT,
      DST_TP,
      DST_PP
   } dst_type;

   typedef struct packed {
      logic [2:0] g_sel;
      logic [2:0] a_sel;
      logic [2:0] b_sel;
      dst_type    dst;
      logic       dbl;
   } term_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PMUL,
      ST_PRND,
      ST_TMUL,
      ST_LAST,
      ST_SAT,
      ST_DET1,
      ST_DET2,
      ST_DET3,
      ST_ROOT,
      ST_ROOTW,
      ST_AMUL,
      ST_AREA,
      ST_DONE
   } state_type;

   // schedule of the pulled-back metric terms
   function automatic term_type term_entry(input logic [TERM_W-1:0] idx);
      term_type e;
      unique case (idx)
         5'd0:  e = '{G_XX, SEL_TX, SEL_TX, DST_TT, 1'b0};
         5'd1:  e = '{G_YY, SEL_TY, SEL_TY, DST_TT, 1'b0};
         5'd2:  e = '{G_ZZ, SEL_TZ, SEL_TZ, DST_TT, 1'b0};
         5'd3:  e = '{G_XY, SEL_TX, SEL_TY, DST_TT, 1'b1};
         5'd4:  e = '{G_XZ, SEL_TX, SEL_TZ, DST_TT, 1'b1};
         5'd5:  e = '{G_YZ, SEL_TY, SEL_TZ, DST_TT, 1'b1};
         5'd6:  e = '{G_XX, SEL_FX, SEL_FX, DST_PP, 1'b0};
         5'd7:  e = '{G_YY, SEL_FY, SEL_FY, DST_PP, 1'b0};
         5'd8:  e = '{G_ZZ, SEL_FZ, SEL_FZ, DST_PP, 1'b0};
         5'd9:  e = '{G_XY, SEL_FX, SEL_FY, DST_PP, 1'b1};
         5'd10: e = '{G_XZ, SEL_FX, SEL_FZ, DST_PP, 1'b1};
         5'd11: e = '{G_YZ, SEL_FY, SEL_FZ, DST_PP, 1'b1};
         5'd12: e = '{G_XX, SEL_TX, SEL_FX, DST_TP, 1'b0};
         5'd13: e = '{G_YY, SEL_TY, SEL_FY, DST_TP, 1'b0};
         5'd14: e = '{G_ZZ, SEL_TZ, SEL_FZ, DST_TP, 1'b0};
         5'd15: e = '{G_XY, SEL_TX, SEL_FY, DST_TP, 1'b0};
         5'd16: e = '{G_XY, SEL_TY, SEL_FX, DST_TP, 1'b0};
         5'd17: e = '{G_XZ, SEL_TX, SEL_FZ, DST_TP, 1'b0};
         5'd18: e = '{G_XZ, SEL_TZ, SEL_FX, DST_TP, 1'b0};
         5'd19: e = '{G_YZ, SEL_TY, SEL_FZ, DST_TP, 1'b0};
         5'd20: e = '{G_YZ, SEL_TZ, SEL_FY, DST_TP, 1'b0};
         default: e = '{G_XX, SEL_TX, SEL_TX, DST_TT, 1'b0};
      endcase
      return e;
   endfunction

   function automatic logic signed [COMP_W-1:0] pick_comp(input req_type r,
                                                         input logic [2:0] sel);
      logic signed [COMP_W-1:0] v;
      unique case (sel)
         SEL_TX:  v = r.comp_a;
         SEL_TY:  v = r.comp_b;
         SEL_TZ:  v = r.comp_c;
         SEL_FX:  v = r.comp_d;
         SEL_FY:  v = r.comp_e;
         SEL_FZ:  v = r.comp_f;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [COMP_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = 66'sh0_7FFF_FFFF;
      lo = -66'sh0_8000_0000;
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[COMP_W-1:0];
   endfunction

endpackage

@@ hdl/imae_sqrt.sv @@
module imae_sqrt
   import imae_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   // two radicand bits, one root bit per step, 32 steps
   localparam int STEPS = RAD_W / 2;

   logic [RAD_W-1:0]  rem_ff, rem_in;
   logic [RAD_W-1:0]  res_ff, res_in;
   logic [RAD_W-1:0]  sqbit_ff, sqbit_in;
   logic [TERM_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [RAD_W-1:0]  trial;

   assign trial = res_ff + sqbit_ff;

   always_comb begin
      rem_in   = rem_ff;
      res_in   = res_ff;
      sqbit_in = sqbit_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = radicand;
         res_in   = '0;
         sqbit_in = RAD_W'(1) << (RAD_W - 2);
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + sqbit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         sqbit_in = sqbit_ff >> 2;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == TERM_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      res_ff   <= res_in;
      sqbit_ff <= sqbit_in;
      cnt_ff   <= cnt_in;
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

@@ hdl/induced_metric_area_element_core.sv @@
// Pulls a stored symmetric 3D metric back onto a surface point. A request with
// mode 0 overwrites the six metric components (xx, xy, xz, yy, yz, zz) and
// gives no response; after reset the store holds the identity metric.
// A request with mode 1 carries the theta tangent (comp_a..c), the phi tangent
// (comp_d..f) and a quadrature weight, and gives one response with the
// saturated induced metric gamma_tt, gamma_tp, gamma_pp and the area element
// sqrt(det) * weight (zero when det is not positive), all Q(31-F).F.
// A compute request occupies the block for 21 metric terms (pair product, round,
// term product) on the one shared 33x33 multiplier, the determinant and, when
// the determinant is positive, a 32-step bit-serial square root. req_stall is
// high for that whole time. A finished
// response sits in an output register, so the next request is taken while the
// previous response still waits on rsp_stall.
module induced_metric_area_element_core
   import imae_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // fixed point constants
   localparam logic signed [COMP_W-1:0] ONE_Q    = COMP_W'(1) << FRAC_BITS;
   localparam logic signed [PROD_W-1:0] HALF     = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] PAIR_LIM = 66'sh0_FFFF_FFFF;
   localparam logic signed [PROD_W-1:0] AREA_MAX = 66'sh0_7FFF_FFFF;

   // sequencer
   state_type state_ff, state_in;
   logic [TERM_W-1:0] term_idx_ff, term_idx_in;
   logic [TERM_W-1:0] fetch_idx;
   term_type          cur_term;
   term_type          fetch_term;

   // captured request and metric store
   req_type                  req_ff, req_in;
   logic signed [COMP_W-1:0] metric_ff [NUM_COMP];
   logic signed [COMP_W-1:0] metric_in [NUM_COMP];

   // operand registers for the shared multiplier
   logic signed [COMP_W-1:0] op_a_ff, op_a_in;
   logic signed [COMP_W-1:0] op_b_ff, op_b_in;
   logic signed [COMP_W-1:0] g_ff, g_in;
   logic signed [MUL_W-1:0]  pair_ff, pair_in;
   logic signed [MUL_W-1:0]  mul_x, mul_y;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] rnd;
   logic signed [PROD_W-1:0] add_val;

   // accumulators, one per induced metric component
   logic signed [PROD_W-1:0] acc_tt_ff, acc_tt_in;
   logic signed [PROD_W-1:0] acc_tp_ff, acc_tp_in;
   logic signed [PROD_W-1:0] acc_pp_ff, acc_pp_in;
   logic    acc_pend_ff, acc_pend_in;
   dst_type acc_dst_ff, acc_dst_in;
   logic    acc_dbl_ff, acc_dbl_in;

   // saturated outputs, determinant and area
   logic signed [COMP_W-1:0] gam_tt_ff, gam_tt_in;
   logic signed [COMP_W-1:0] gam_tp_ff, gam_tp_in;
   logic signed [COMP_W-1:0] gam_pp_ff, gam_pp_in;
   logic signed [PROD_W-1:0] det_ff, det_in;
   logic [AREA_W-1:0]        area_ff, area_in;

   // response register
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // square root unit
   logic              sq_start;
   logic              sq_done;
   logic [ROOT_W-1:0] sq_root;

   imae_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (det_ff[RAD_W-1:0]),
      .done     (sq_done),
      .root     (sq_root)
   );

   // round half up to F fraction bits (arithmetic shift is floor)
   assign rnd     = (prod_ff + HALF) >>> FRAC_BITS;
   // off-diagonal terms of the diagonal forms count twice
   assign add_val = acc_dbl_ff ? (rnd <<< 1) : rnd;

   // term being multiplied, and term whose operands are fetched
   assign cur_term   = term_entry(term_idx_ff);
   assign fetch_idx  = (state_ff == ST_FETCH) ? term_idx_ff : term_idx_ff + 1'b1;
   assign fetch_term = term_entry(fetch_idx);

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         ST_PMUL: begin
            mul_x = MUL_W'(op_a_ff);
            mul_y = MUL_W'(op_b_ff);
         end
         ST_TMUL: begin
            mul_x = MUL_W'(g_ff);
            mul_y = pair_ff;
         end
         ST_DET1: begin
            mul_x = MUL_W'(gam_tt_ff);
            mul_y = MUL_W'(gam_pp_ff);
         end
         ST_DET2: begin
            mul_x = MUL_W'(gam_tp_ff);
            mul_y = MUL_W'(gam_tp_ff);
         end
         ST_AMUL: begin
            mul_x = {1'b0, sq_root};
            mul_y = {2'b00, req_ff.quad_weight};
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign prod_in = mul_x * mul_y;

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      term_idx_in  = term_idx_ff;
      req_in       = req_ff;
      metric_in    = metric_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      g_in         = g_ff;
      pair_in      = pair_ff;
      acc_tt_in    = acc_tt_ff;
      acc_tp_in    = acc_tp_ff;
      acc_pp_in    = acc_pp_ff;
      acc_pend_in  = 1'b0;
      acc_dst_in   = acc_dst_ff;
      acc_dbl_in   = acc_dbl_ff;
      gam_tt_in    = gam_tt_ff;
      gam_tp_in    = gam_tp_ff;
      gam_pp_in    = gam_pp_ff;
      det_in       = det_ff;
      area_in      = area_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sq_start     = 1'b0;

      // finished term product is accumulated in the cycle after its multiply
      if (acc_pend_ff) begin
         unique case (acc_dst_ff)
            DST_TT:  acc_tt_in = acc_tt_ff + add_val;
            DST_TP:  acc_tp_in = acc_tp_ff + add_val;
            DST_PP:  acc_pp_in = acc_pp_ff + add_val;
            default: acc_tt_in = acc_tt_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.mode == MODE_CALC) begin
                  req_in      = req_data;
                  acc_tt_in   = '0;
                  acc_tp_in   = '0;
                  acc_pp_in   = '0;
                  term_idx_in = '0;
                  state_in    = ST_FETCH;
               end else begin
                  metric_in[G_XX] = req_data.comp_a;
                  metric_in[G_XY] = req_data.comp_b;
                  metric_in[G_XZ] = req_data.comp_c;
                  metric_in[G_YY] = req_data.comp_d;
                  metric_in[G_YZ] = req_data.comp_e;
                  metric_in[G_ZZ] = req_data.comp_f;
               end
            end
         end
         ST_FETCH: begin
            op_a_in  = pick_comp(req_ff, fetch_term.a_sel);
            op_b_in  = pick_comp(req_ff, fetch_term.b_sel);
            g_in     = metric_ff[fetch_term.g_sel];
            state_in = ST_PMUL;
         end
         // tangent pair product
         ST_PMUL: begin
            state_in = ST_PRND;
         end
         // round and clamp the pair to +-(2^32 - 1)
         ST_PRND: begin
            if (rnd > PAIR_LIM) begin
               pair_in = MUL_W'(PAIR_LIM);
            end else if (rnd < -PAIR_LIM) begin
               pair_in = MUL_W'(-PAIR_LIM);
            end else begin
               pair_in = rnd[MUL_W-1:0];
            end
            state_in = ST_TMUL;
         end
         // metric times pair, prefetch next term operands
         ST_TMUL: begin
            acc_pend_in = 1'b1;
            acc_dst_in  = cur_term.dst;
            acc_dbl_in  = cur_term.dbl;
            if (term_idx_ff == TERM_W'(NUM_TERMS - 1)) begin
               state_in = ST_LAST;
            end else begin
               term_idx_in = term_idx_ff + 1'b1;
               op_a_in     = pick_comp(req_ff, fetch_term.a_sel);
               op_b_in     = pick_comp(req_ff, fetch_term.b_sel);
               g_in        = metric_ff[fetch_term.g_sel];
               state_in    = ST_PMUL;
            end
         end
         ST_LAST: begin
            state_in = ST_SAT;
         end
         ST_SAT: begin
            gam_tt_in = sat32(acc_tt_ff);
            gam_tp_in = sat32(acc_tp_ff);
            gam_pp_in = sat32(acc_pp_ff);
            state_in  = ST_DET1;
         end
         // det = tt * pp - tp * tp, exact
         ST_DET1: begin
            state_in = ST_DET2;
         end
         ST_DET2: begin
            det_in   = prod_ff;
            state_in = ST_DET3;
         end
         ST_DET3: begin
            det_in   = det_ff - prod_ff;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (!det_ff[PROD_W-1] && (det_ff != '0)) begin
               sq_start = 1'b1;
               state_in = ST_ROOTW;
            end else begin
               area_in  = '0;
               state_in = ST_DONE;
            end
         end
         ST_ROOTW: begin
            if (sq_done) begin
               state_in = ST_AMUL;
            end
         end
         // root times weight
         ST_AMUL: begin
            state_in = ST_AREA;
         end
         ST_AREA: begin
            if (rnd > AREA_MAX) begin
               area_in = AREA_W'(AREA_MAX);
            end else begin
               area_in = rnd[AREA_W-1:0];
            end
            state_in = ST_DONE;
         end
         // hand over once the response register is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.gamma_tt     = gam_tt_ff;
               rsp_in.gamma_tp     = gam_tp_ff;
               rsp_in.gamma_pp     = gam_pp_ff;
               rsp_in.area_element = area_ff;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and metric store
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         acc_pend_ff     <= 1'b0;
         metric_ff[G_XX] <= ONE_Q;
         metric_ff[G_XY] <= '0;
         metric_ff[G_XZ] <= '0;
         metric_ff[G_YY] <= ONE_Q;
         metric_ff[G_YZ] <= '0;
         metric_ff[G_ZZ] <= ONE_Q;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_pend_ff  <= acc_pend_in;
         metric_ff    <= metric_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      term_idx_ff <= term_idx_in;
      req_ff      <= req_in;
      op_a_ff     <= op_a_in;
      op_b_ff     <= op_b_in;
      g_ff        <= g_in;
      pair_ff     <= pair_in;
      prod_ff     <= prod_in;
      acc_tt_ff   <= acc_tt_in;
      acc_tp_ff   <= acc_tp_in;
      acc_pp_ff   <= acc_pp_in;
      acc_dst_ff  <= acc_dst_in;
      acc_dbl_ff  <= acc_dbl_in;
      gam_tt_ff   <= gam_tt_in;
      gam_tp_ff   <= gam_tp_in;
      gam_pp_ff   <= gam_pp_in;
      det_ff      <= det_in;
      area_ff     <= area_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
